@@ hw/rtl/work_deque_with_recent_slot_top_assert.svh @@
// Assertion macros shared by the work deque RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef WORK_DEQUE_WITH_RECENT_SLOT_TOP_ASSERT_SVH
`define WORK_DEQUE_WITH_RECENT_SLOT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge out of reset
`define WDQ_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("wdq assertion failed");
// Consequent must hold in the same cycle as the antecedent
`define WDQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wdq assertion failed");
// Consequent must hold in the cycle after the antecedent
`define WDQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wdq assertion failed");
`else
`define WDQ_ASSERT_ALWAYS(label, clk, rstn, cond)
`define WDQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define WDQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/wdq_pkg.sv @@
// Package for the work deque: operation codes, field widths and defaults.
// No dependencies.
`timescale 1ns / 1ps

package wdq_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_POP_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_BACK  = 2'd2;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 32;
    localparam int TIME_W   = 48;

    // transaction payload widths, padded to whole bytes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - (4 + HANDLE_W + TIME_W);

    localparam int QUEUE_DEPTH_DEF = 16;

endpackage

@@ hw/rtl/wdq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write, and read old contents on an address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/work_deque_with_recent_slot_top.sv @@
// Work deque top level: recent slot in front of a ring deque held in two RAMs.
// Depends on wdq_pkg, wdq_ram and work_deque_with_recent_slot_top_assert.svh.
//
// A task queue: add places a task in a one-entry recent slot, pushing any task
// already there onto the back of a QUEUE_DEPTH-entry ring deque (refused when
// the deque is full). Pop front takes the deque front, else the slot; pop back
// takes the slot, else the deque back. Every transaction returns one result
// with emptiness and the oldest enqueue time. One transaction is accepted per
// cycle while s_tready is high; each result passes the RAM read stage, then the
// result register. The slot, head and count update at the accepting edge,
// where the RAM reads for the popped handle and the new oldest time are
// launched. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "work_deque_with_recent_slot_top_assert.svh"

module work_deque_with_recent_slot_top #(
    parameter int QUEUE_DEPTH = wdq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] task_handle, [79:32] enqueue_time
    input  logic [wdq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [wdq_pkg::OP_W-1:0]      s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] popped_valid, [32:1] popped_handle, [33] add_refused,
    // [34] queue_empty, [35] oldest_valid, [83:36] oldest_time, [87:84] zero
    output logic [wdq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int HW    = wdq_pkg::HANDLE_W;
    localparam int TW    = wdq_pkg::TIME_W;

    // ring position of base plus offset, offset below the depth
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [SUM_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + offs;
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // queue state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             slot_valid_reg, slot_valid_next;
    logic [HW-1:0]    slot_handle_reg, slot_handle_next;
    logic [TW-1:0]    slot_time_reg, slot_time_next;

    // read stage
    logic             p1_valid_reg;
    logic             p1_popped_reg;
    logic             p1_pop_ram_reg;
    logic [HW-1:0]    p1_handle_reg;
    logic             p1_refused_reg;
    logic             p1_have_reg;
    logic             p1_oldest_ram_reg;
    logic [TW-1:0]    p1_time_reg;

    // result stage
    logic                          out_valid_reg;
    logic [wdq_pkg::M_TDATA_W-1:0] out_data_reg;

    logic [wdq_pkg::OP_W-1:0] in_op;
    logic [HW-1:0]            in_handle;
    logic [TW-1:0]            in_time;
    logic                     s_accept;
    logic                     p1_advance;

    logic             full;
    logic [IDX_W-1:0] wr_pos, back_pos, head_plus1;
    logic             popped, pop_ram, refused, ram_we;
    logic [IDX_W-1:0] hnd_raddr;
    logic             have_oldest, bypass;
    logic [HW-1:0]    hnd_rdata;
    logic [TW-1:0]    time_rdata;
    logic [HW-1:0]    out_handle;
    logic [TW-1:0]    out_time;

    assign in_op     = s_tuser;
    assign in_handle = s_tdata[HW-1:0];
    assign in_time   = s_tdata[HW+TW-1:HW];

    assign p1_advance = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !p1_valid_reg || !out_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign wr_pos     = ring_pos(head_reg, SUM_W'(count_reg));
    assign back_pos   = ring_pos(head_reg, SUM_W'(count_reg - CNT_W'(1)));
    assign head_plus1 = ring_pos(head_reg, SUM_W'(1));

    // next queue state for the presented operation
    always_comb begin
        head_next        = head_reg;
        count_next       = count_reg;
        slot_valid_next  = slot_valid_reg;
        slot_handle_next = slot_handle_reg;
        slot_time_next   = slot_time_reg;
        popped           = 1'b0;
        pop_ram          = 1'b0;
        refused          = 1'b0;
        ram_we           = 1'b0;
        hnd_raddr        = head_reg;
        case (in_op)
            wdq_pkg::OP_ADD: begin
                if (slot_valid_reg && full) begin
                    refused = 1'b1;
                end else begin
                    if (slot_valid_reg) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    slot_valid_next  = 1'b1;
                    slot_handle_next = in_handle;
                    slot_time_next   = in_time;
                end
            end
            wdq_pkg::OP_POP_FRONT: begin
                if (count_reg != '0) begin
                    popped     = 1'b1;
                    pop_ram    = 1'b1;
                    hnd_raddr  = head_reg;
                    count_next = count_reg - CNT_W'(1);
                    head_next  = (count_reg == CNT_W'(1)) ? '0 : head_plus1;
                end else if (slot_valid_reg) begin
                    popped          = 1'b1;
                    slot_valid_next = 1'b0;
                end
            end
            wdq_pkg::OP_POP_BACK: begin
                if (slot_valid_reg) begin
                    popped          = 1'b1;
                    slot_valid_next = 1'b0;
                end else if (count_reg != '0) begin
                    popped     = 1'b1;
                    pop_ram    = 1'b1;
                    hnd_raddr  = back_pos;
                    count_next = count_reg - CNT_W'(1);
                    head_next  = (count_reg == CNT_W'(1)) ? '0 : head_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // oldest entry after the step; forward the time being written this edge
    assign have_oldest = (count_next != '0) || slot_valid_next;
    assign bypass      = ram_we && (head_next == wr_pos);

    // queue control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            count_reg      <= '0;
            slot_valid_reg <= 1'b0;
        end else if (s_accept) begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_handle_reg <= slot_handle_next;
            slot_time_reg   <= slot_time_next;
        end
    end

    wdq_ram #(
        .WIDTH (HW),
        .DEPTH (QUEUE_DEPTH)
    ) u_handle_ram (
        .aclk    (aclk),
        .wr_en   (s_accept && ram_we),
        .wr_addr (wr_pos),
        .wr_data (slot_handle_reg),
        .rd_en   (s_accept && pop_ram),
        .rd_addr (hnd_raddr),
        .rd_data (hnd_rdata)
    );

    wdq_ram #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_time_ram (
        .aclk    (aclk),
        .wr_en   (s_accept && ram_we),
        .wr_addr (wr_pos),
        .wr_data (slot_time_reg),
        .rd_en   (s_accept),
        .rd_addr (head_next),
        .rd_data (time_rdata)
    );

    // read stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    // read stage side information
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_popped_reg     <= popped;
            p1_pop_ram_reg    <= pop_ram;
            p1_handle_reg     <= slot_handle_reg;
            p1_refused_reg    <= refused;
            p1_have_reg       <= have_oldest;
            p1_oldest_ram_reg <= (count_next != '0) && !bypass;
            p1_time_reg       <= bypass ? slot_time_reg : slot_time_next;
        end
    end

    // select result fields
    always_comb begin
        out_handle = '0;
        out_time   = '0;
        if (p1_popped_reg) begin
            out_handle = p1_pop_ram_reg ? hnd_rdata : p1_handle_reg;
        end
        if (p1_have_reg) begin
            out_time = p1_oldest_ram_reg ? time_rdata : p1_time_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            out_data_reg <= {{wdq_pkg::M_PAD_W{1'b0}}, out_time, p1_have_reg,
                             !p1_have_reg, p1_refused_reg, out_handle, p1_popped_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `WDQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `WDQ_ASSERT_IMPLIES(a_empty_head, aclk, aresetn, count_reg == '0, head_reg == '0)
    `WDQ_ASSERT_IMPLIES(a_ready_stall, aclk, aresetn, !s_tready, p1_valid_reg && out_valid_reg && !m_tready)
    `WDQ_ASSERT_IMPLIES(a_empty_flag, aclk, aresetn, out_valid_reg, out_data_reg[34] != out_data_reg[35])
    `WDQ_ASSERT_NEXT(a_refused_hold, aclk, aresetn, s_accept && refused, count_reg == $past(count_reg) && slot_valid_reg)

endmodule
